/* sv/csle_pkg.sv */
// Package for the C string literal escaper.
// Holds the payload and command types, character constants and the hex digit helper.
// No dependencies.
package csle_pkg;

    localparam int unsigned QUEUE_DEPTH     = 2;
    localparam int unsigned MAX_CHARS       = 8;
    localparam logic [7:0]  LINE_LIMIT_INIT = 8'd79;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out_item;

    // One input byte expanded: up to eight characters and the index of the final one.
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [2:0]                last_idx;
    } t_cmd;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            hex_char = 8'h30 + {4'd0, nib};
        end else begin
            hex_char = 8'h41 + {4'd0, nib} - 8'd10;
        end
    endfunction

endpackage

/* sv/c_string_literal_escaper.sv */
// C string literal escaper: one raw byte per input transaction becomes one to eight
// characters of C literal text, one character per output transaction, with last_char
// set on the final character of each byte. Backslash, tab and double quote become
// two-character escapes, printable bytes pass (after a "" break if the byte before was
// a hex escape), all others become \xHH. Lines open with newline and quote and close
// with a quote once their length reaches line_limit; end_of_buffer closes any open
// line and adds a semicolon. Throughput is set by the output port, and the next byte's
// characters follow the last with no gap when its command is already queued. Input is
// taken one byte per cycle while the command queue (QUEUE_DEPTH entries) has room. A
// byte's command passes through the queue and then the back end's current command
// register before its first character is offered. line_limit is written on the config
// channel, which is always ready; write it only while the block is idle.
// Depends on csle_pkg, csle_front, csle_queue, csle_back.
module c_string_literal_escaper #(
    parameter int unsigned QUEUE_DEPTH = csle_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // byte input channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  csle_pkg::t_in_item  i_in_item,
    // character output channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output csle_pkg::t_out_item o_out_item,
    // line_limit write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);
    import csle_pkg::*;

    logic q_full, q_empty, push, pop;
    t_cmd push_cmd, head_cmd;

    // classify and expand; state advances on each accepted transaction
    csle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // decouples input acceptance from output stalls
    csle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    // serializer
    csle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

/* sv/csle_front.sv */
// Front end: accepts raw bytes, classifies them and builds the character command.
// Owns line_limit, line length and hex-break state. Depends on csle_pkg.
module csle_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  csle_pkg::t_in_item i_in_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_q_full,
    output logic              o_push,
    output csle_pkg::t_cmd    o_cmd
);
    import csle_pkg::*;

    logic [7:0] r_line_limit;
    logic [7:0] r_line_count, n_line_count;
    logic       r_prev_hex, n_prev_hex;
    logic [8:0] len;
    logic [3:0] n;
    logic [7:0] b;

    assign o_in_ready  = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign o_push      = i_in_valid && !i_q_full;
    assign b           = i_in_item.data_byte;

    always_comb begin
        o_cmd.chars = '0;
        n           = 4'd0;
        len         = {1'b0, r_line_count};
        n_prev_hex  = r_prev_hex;

        if (r_line_count == 8'd0) begin
            o_cmd.chars[0] = CH_NL;
            o_cmd.chars[1] = CH_QUOTE;
            n   = 4'd2;
            len = 9'd1;
        end

        if (b == CH_BSLASH || b == CH_TAB || b == CH_QUOTE) begin
            o_cmd.chars[n[2:0]]        = CH_BSLASH;
            o_cmd.chars[n[2:0] + 3'd1] = (b == CH_TAB) ? CH_T : b;
            n          = n + 4'd2;
            len        = len + 9'd2;
            n_prev_hex = 1'b0;
        end else if (b >= CH_SPACE && b <= CH_TILDE) begin
            if (r_prev_hex) begin
                o_cmd.chars[n[2:0]]        = CH_QUOTE;
                o_cmd.chars[n[2:0] + 3'd1] = CH_QUOTE;
                n   = n + 4'd2;
                len = len + 9'd2;
            end
            o_cmd.chars[n[2:0]] = b;
            n          = n + 4'd1;
            len        = len + 9'd1;
            n_prev_hex = 1'b0;
        end else begin
            o_cmd.chars[n[2:0]]        = CH_BSLASH;
            o_cmd.chars[n[2:0] + 3'd1] = CH_X;
            o_cmd.chars[n[2:0] + 3'd2] = hex_char(b[7:4]);
            o_cmd.chars[n[2:0] + 3'd3] = hex_char(b[3:0]);
            n          = n + 4'd4;
            len        = len + 9'd4;
            n_prev_hex = 1'b1;
        end

        // line full: close it
        if (len >= {1'b0, r_line_limit}) begin
            o_cmd.chars[n[2:0]] = CH_QUOTE;
            n          = n + 4'd1;
            len        = 9'd0;
            n_prev_hex = 1'b0;
        end

        if (i_in_item.end_of_buffer) begin
            if (len != 9'd0) begin
                o_cmd.chars[n[2:0]] = CH_QUOTE;
                n = n + 4'd1;
            end
            o_cmd.chars[n[2:0]] = CH_SEMI;
            n          = n + 4'd1;
            len        = 9'd0;
            n_prev_hex = 1'b0;
        end

        n_line_count   = len[7:0];
        o_cmd.last_idx = 3'(n - 4'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit <= LINE_LIMIT_INIT;
            r_line_count <= 8'd0;
            r_prev_hex   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_line_limit <= i_cfg_data;
            end
            if (o_push) begin
                r_line_count <= n_line_count;
                r_prev_hex   <= n_prev_hex;
            end
        end
    end

endmodule

/* sv/csle_queue.sv */
// Short command queue between front and back ends.
// Depth set by DEPTH (at least 2). Depends on csle_pkg.
module csle_queue #(
    parameter int unsigned DEPTH = csle_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  csle_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output csle_pkg::t_cmd o_head
);
    import csle_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/csle_back.sv */
// Back end: plays out one command, one character per cycle unless stalled, flagging
// the last. Pulls the next command as the current one ends. Depends on csle_pkg.
module csle_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  csle_pkg::t_cmd      i_q_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output csle_pkg::t_out_item o_out_item
);
    import csle_pkg::*;

    logic       r_busy;
    t_cmd       r_cur;
    logic [2:0] r_idx;
    logic       fire, at_end;

    assign o_out_valid          = r_busy;
    assign at_end               = (r_idx == r_cur.last_idx);
    assign fire                 = r_busy && i_out_ready;
    assign o_pop                = !i_q_empty && (!r_busy || (fire && at_end));
    assign o_out_item.out_char  = r_cur.chars[r_idx];
    assign o_out_item.last_char = at_end;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_q_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 3'd0;
            end else if (fire) begin
                if (at_end) begin
                    r_busy <= 1'b0;
                    r_idx  <= 3'd0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

endmodule

/* sv/csle_checker.sv */
// Port-level checks for the C string literal escaper, bound to the top level.
// Depends on csle_pkg and c_string_literal_escaper.
module csle_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input csle_pkg::t_out_item o_out_item,
    input logic                o_cfg_ready
);
    import csle_pkg::*;

    // output transaction held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output transaction dropped or changed while stalled");

    // nothing pending right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // newline only opens a line, so never ends a byte's characters
    a_nl_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.out_char == CH_NL |-> !o_out_item.last_char)
        else $error("newline flagged as last character");

    // a newline is always followed by the opening quote
    a_nl_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_item.out_char == CH_NL
        |=> o_out_valid && o_out_item.out_char == CH_QUOTE)
        else $error("newline not followed by quote");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config channel not ready");

endmodule

bind c_string_literal_escaper csle_checker u_csle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item),
    .o_cfg_ready (o_cfg_ready)
);

/* tb/sv/c_string_literal_escaper_test.sv */
// Self-checking testbench for c_string_literal_escaper.
// Depends on csle_pkg and the c_string_literal_escaper RTL; no files, no arguments.
`timescale 1ns / 100ps

module c_string_literal_escaper_test;
    import csle_pkg::*;

    // Run length guards
    localparam int unsigned CYCLE_LIMIT  = 200_000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned MAX_REPORTS  = 10;

    // Directed script: each row is either a byte transaction or a line_limit write.
    // Rows with text hold the exact characters expected for that byte; rows
    // without text are checked against the predictor instead.
    typedef enum logic [0:0] {
        ROW_BYTE,
        ROW_LIMIT
    } t_row_kind;

    typedef struct {
        t_row_kind  kind;
        logic [7:0] value;
        logic       eob;
        string      text;
    } t_row;

    localparam int N_ROWS = 29;

    t_row script [N_ROWS] = '{
        // default limit of 79: one of each byte class, breaks after hex escapes
        '{ROW_BYTE,  8'h41,     1'b0, "\n\"A"},
        '{ROW_BYTE,  8'h00,     1'b0, "\\x00"},
        '{ROW_BYTE,  8'h42,     1'b0, "\"\"B"},
        '{ROW_BYTE,  8'hFF,     1'b0, "\\xFF"},
        '{ROW_BYTE,  CH_TAB,    1'b0, "\\t"},
        '{ROW_BYTE,  CH_BSLASH, 1'b0, "\\\\"},
        '{ROW_BYTE,  CH_QUOTE,  1'b0, "\\\""},
        '{ROW_BYTE,  CH_SPACE,  1'b0, " "},
        '{ROW_BYTE,  CH_TILDE,  1'b0, "~"},
        '{ROW_BYTE,  8'h1F,     1'b0, "\\x1F"},
        '{ROW_BYTE,  8'h7F,     1'b0, "\\x7F"},
        '{ROW_BYTE,  CH_SPACE,  1'b0, "\"\" "},
        '{ROW_BYTE,  8'h80,     1'b0, "\\x80"},
        // end of buffer with a line open and a hex escape pending
        '{ROW_BYTE,  8'h7A,     1'b1, "\"\"z\";"},
        // one-byte buffers: the longest expansion, and the plainest
        '{ROW_BYTE,  8'hAA,     1'b1, "\n\"\\xAA\";"},
        '{ROW_BYTE,  8'h5A,     1'b1, "\n\"Z\";"},
        // limit of 8: line close, and close clearing the hex flag
        '{ROW_LIMIT, 8'd8,      1'b0, ""},
        '{ROW_BYTE,  8'h01,     1'b0, "\n\"\\x01"},
        '{ROW_BYTE,  8'h41,     1'b0, "\"\"A\""},
        '{ROW_BYTE,  8'h01,     1'b0, "\n\"\\x01"},
        '{ROW_BYTE,  8'h02,     1'b0, "\\x02\""},
        '{ROW_BYTE,  8'h43,     1'b0, "\n\"C"},
        '{ROW_BYTE,  8'h44,     1'b1, "D\";"},
        // limits of zero and one close the line after every byte
        '{ROW_LIMIT, 8'd0,      1'b0, ""},
        '{ROW_BYTE,  8'h45,     1'b0, "\n\"E\""},
        '{ROW_BYTE,  8'h00,     1'b1, "\n\"\\x00\";"},
        '{ROW_LIMIT, 8'd1,      1'b0, ""},
        '{ROW_BYTE,  CH_QUOTE,  1'b0, "\n\"\\\"\""},
        '{ROW_BYTE,  CH_SPACE,  1'b1, "\n\" \";"}
    };

    // DUT ports, the inputs known from time zero
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_item   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_item;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data  = 8'd0;

    // Script row behind the byte on the input channel, -1 for random bytes.
    // Travels with the payload so the monitor sees it at the accepting edge.
    int pin_row = -1;

    // Predictor state: mirrors line_count, the hex flag and line_limit
    logic [7:0] line_len  = 8'd0;
    logic       after_hex = 1'b0;
    logic [7:0] limit_now = LINE_LIMIT_INIT;

    // Characters still owed by the DUT, oldest first
    t_out_item expected_chars [$];

    // Both sides idle at random unless this is set
    bit no_idle = 1'b0;

    int unsigned err_count     = 0;
    int unsigned bytes_in      = 0;
    int unsigned buffers_in    = 0;
    int unsigned chars_checked = 0;
    int unsigned limit_writes  = 0;
    int unsigned cycles        = 0;

    c_string_literal_escaper u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Run guard: a hung handshake ends here
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d characters still owed",
                     cycles, expected_chars.size());
            $display("c_string_literal_escaper_test: done, errors");
            $finish;
        end
    end

    // Receiver backpressure: stalls about 18 percent of the time unless no_idle is set
    always @(posedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(99) >= 18);
    end

    function automatic void report_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 | {4'd0, nib}) : (8'h37 + {4'd0, nib});
    endfunction

    // Spell one accepted byte as literal text and queue the characters.
    // A pinned script row with text overrides the spelled text but state still advances.
    function automatic void spell_byte(input t_in_item it, input int row);
        logic [7:0]  spelled [$];
        logic [7:0]  b;
        int unsigned len;
        string       text;
        t_out_item   ch;
        b   = it.data_byte;
        len = line_len;
        if (len == 0) begin
            spelled.push_back(CH_NL);
            spelled.push_back(CH_QUOTE);
            len = 1;
        end
        if (b == CH_BSLASH || b == CH_TAB || b == CH_QUOTE) begin
            spelled.push_back(CH_BSLASH);
            spelled.push_back((b == CH_TAB) ? CH_T : b);
            len += 2;
            after_hex = 1'b0;
        end else if (b >= CH_SPACE && b <= CH_TILDE) begin
            // empty-string break keeps a following hex-looking char out of the escape
            if (after_hex) begin
                spelled.push_back(CH_QUOTE);
                spelled.push_back(CH_QUOTE);
                len += 2;
            end
            spelled.push_back(b);
            len += 1;
            after_hex = 1'b0;
        end else begin
            spelled.push_back(CH_BSLASH);
            spelled.push_back(CH_X);
            spelled.push_back(hex_digit(b[7:4]));
            spelled.push_back(hex_digit(b[3:0]));
            len += 4;
            after_hex = 1'b1;
        end
        // len is an int here, so a limit near 255 cannot wrap
        if (len >= limit_now) begin
            spelled.push_back(CH_QUOTE);
            len = 0;
            after_hex = 1'b0;
        end
        if (it.end_of_buffer) begin
            if (len != 0) begin
                spelled.push_back(CH_QUOTE);
            end
            spelled.push_back(CH_SEMI);
            len = 0;
            after_hex = 1'b0;
            buffers_in++;
        end
        line_len = len[7:0];
        bytes_in++;

        if (row >= 0 && script[row].text.len() != 0) begin
            text = script[row].text;
            spelled.delete();
            for (int k = 0; k < text.len(); k++) begin
                spelled.push_back(text[k]);
            end
        end
        foreach (spelled[k]) begin
            ch.out_char  = spelled[k];
            ch.last_char = (k == spelled.size() - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    function automatic void check_char(input t_out_item got);
        t_out_item want;
        if (expected_chars.size() == 0) begin
            report_error($sformatf("char 0x%02h last=%0b with nothing expected",
                                   got.out_char, got.last_char));
            return;
        end
        want = expected_chars.pop_front();
        chars_checked++;
        if (got.out_char !== want.out_char) begin
            report_error($sformatf("out_char expected 0x%02h, got 0x%02h",
                                   want.out_char, got.out_char));
        end
        if (got.last_char !== want.last_char) begin
            report_error($sformatf("last_char expected %0b, got %0b (char 0x%02h)",
                                   want.last_char, got.last_char, want.out_char));
        end
    endfunction

    // Monitor: predict on accepted bytes first, then check accepted characters,
    // so a character taken at the same edge as its byte still finds its expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                spell_byte(i_in_item, pin_row);
            end
            if (o_out_valid && i_out_ready) begin
                check_char(o_out_item);
            end
        end
    end

    // Drop valid and wait until every owed character has been taken.
    // Always waits for a clock edge first, so a just-accepted byte is already queued.
    task automatic wait_all_out();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_chars.size() != 0);
    endtask

    // One byte transaction, with an occasional gap ahead of it.
    // Valid is left high on return; the next call or wait_all_out decides.
    task automatic send_byte(input logic [7:0] b, input logic eob, input int row);
        int unsigned gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 18) begin
            gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{data_byte: b, end_of_buffer: eob};
        pin_row    <= row;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    // line_limit is only written with the block drained
    task automatic write_limit(input logic [7:0] value);
        wait_all_out();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        limit_now = value;
        limit_writes++;
    endtask

    // Byte mix: ~10% two-char escapes, hex_pct nonprintables, rest printable
    function automatic logic [7:0] random_byte(input int unsigned hex_pct);
        int unsigned roll;
        int unsigned v;
        roll = $urandom_range(99);
        if (roll < 10) begin
            case ($urandom_range(2))
                0: begin
                    return CH_BSLASH;
                end
                1: begin
                    return CH_TAB;
                end
                default: begin
                    return CH_QUOTE;
                end
            endcase
        end
        if (roll < 10 + hex_pct) begin
            // 0x00..0x1F and 0x7F..0xFF
            v = $urandom_range(160);
            if (v >= 32) begin
                v = v + 95;
            end
            return v[7:0];
        end
        v = $urandom_range(32'h20, 32'h7E);
        return v[7:0];
    endfunction

    // Random phase under one limit. hold_at > 0 makes the sender wait for a full
    // drain partway through; calm turns off idling on both sides.
    task automatic run_phase(input logic [7:0] limit, input int unsigned count,
                             input int unsigned eob_pct, input int unsigned hex_pct,
                             input bit calm, input int unsigned hold_at);
        logic [7:0] b;
        write_limit(limit);
        no_idle = calm;
        for (int unsigned n = 0; n < count; n++) begin
            if (hold_at != 0 && n == hold_at) begin
                wait_all_out();
            end
            b = random_byte(hex_pct);
            send_byte(b, ($urandom_range(99) < eob_pct), -1);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part
        foreach (script[i]) begin
            if (script[i].kind == ROW_LIMIT) begin
                write_limit(script[i].value);
            end else begin
                send_byte(script[i].value, script[i].eob, i);
            end
        end

        // Random part. The first two phases run one long line, mostly hex escapes,
        // so it grows past 200 and then closes at the top limit of 255; the second
        // runs with no idling on either side.
        run_phase(8'd200, 35, 0, 75, 1'b0, 17);
        run_phase(8'd255, 45, 0, 85, 1'b1, 0);
        run_phase(8'd8, 10, 10, 40, 1'b0, 0);
        run_phase(8'($urandom_range(9, 199)), 10, 8, 40, 1'b0, 0);
        run_phase(8'($urandom_range(9, 199)), 10, 5, 40, 1'b0, 0);

        wait_all_out();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d bytes in %0d complete buffers, %0d characters checked",
                 bytes_in, buffers_in, chars_checked);
        $display("line_limit written %0d times (0, 1, 8 up to 255), %0d mismatches",
                 limit_writes, err_count);
        if (err_count == 0) begin
            $display("c_string_literal_escaper_test: done, clean");
        end else begin
            $display("c_string_literal_escaper_test: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/csle_pkg.sv
sv/csle_front.sv
sv/csle_queue.sv
sv/csle_back.sv
sv/c_string_literal_escaper.sv
sv/csle_checker.sv
tb/sv/c_string_literal_escaper_test.sv
